// ===== sv/u8rc_pkg.sv =====
// Shared types and constants for the UTF-8 code point range checker.
// No dependencies; imported by every module of the block.
package u8rc_pkg;

    localparam int CP_W      = 21;
    localparam int CNT_W     = 24;
    localparam int KIND_W    = 3;
    localparam int RANGE_W   = 2 * CP_W;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;
    localparam int IDX_W     = 3;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 48;

    localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(22'h200000);
    localparam logic [CNT_W-1:0]   CNT_MAX     = '1;

    localparam logic [KIND_W-1:0] KIND_OUTSIDE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_END       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_LEAD  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BAD_CONT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TRUNCATED = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CP_W-1:0]   char_code;
        logic [CNT_W-1:0]  outside_total;
        logic              run_last;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

// ===== sv/u8rc_cfg_regs.sv =====
// Range configuration registers behind the APB-style port.
// Depends on u8rc_pkg.
module u8rc_cfg_regs #(
    parameter int NUM_RANGES = 8
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [u8rc_pkg::ADDR_W-1:0]             paddr,
    input  logic [u8rc_pkg::DATA_W-1:0]             pwdata,
    output logic [u8rc_pkg::DATA_W-1:0]             prdata,
    output logic                                    pready,
    output logic [NUM_RANGES-1:0][u8rc_pkg::RANGE_W-1:0] ranges
);
    import u8rc_pkg::*;

    logic [NUM_RANGES-1:0][RANGE_W-1:0] range_reg;
    logic [IDX_W-1:0]                   idx;
    logic                               wr_en;

    assign idx    = paddr[ADDR_W-1:3];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign ranges = range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_RANGES; i++) begin
                range_reg[i] <= RANGE_RESET;
            end
        end else if (wr_en) begin
            for (int i = 0; i < NUM_RANGES; i++) begin
                if (idx == IDX_W'(i)) begin
                    range_reg[i] <= pwdata[RANGE_W-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int i = 0; i < NUM_RANGES; i++) begin
            if (idx == IDX_W'(i)) begin
                prdata = DATA_W'(range_reg[i]);
            end
        end
    end

endmodule

// ===== sv/u8rc_range_match.sv =====
// Parallel inclusive range compare of one code point against all ranges.
// Depends on u8rc_pkg.
module u8rc_range_match #(
    parameter int NUM_RANGES = 8
) (
    input  logic [u8rc_pkg::CP_W-1:0]                    cp,
    input  logic [NUM_RANGES-1:0][u8rc_pkg::RANGE_W-1:0] ranges,
    output logic                                         hit
);
    import u8rc_pkg::*;

    logic [NUM_RANGES-1:0] lane_hit;

    always_comb begin
        for (int i = 0; i < NUM_RANGES; i++) begin
            lane_hit[i] = (cp >= ranges[i][RANGE_W-1:CP_W]) && (cp <= ranges[i][CP_W-1:0]);
        end
    end

    assign hit = |lane_hit;

endmodule

// ===== sv/u8rc_decode.sv =====
// Input register, UTF-8 sequence state and result forming for one byte beat.
// Depends on u8rc_pkg; range hit comes from u8rc_range_match.
module u8rc_decode (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  in_byte,
    input  logic                        in_present,
    input  logic                        in_end,
    input  logic                        space_ok,
    input  logic                        hit,
    output logic [u8rc_pkg::CP_W-1:0]   cand_cp,
    output u8rc_pkg::push_t             push
);
    import u8rc_pkg::*;

    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic             present_reg;
    logic             end_reg;
    logic [1:0]       rem_reg, rem_next;
    logic [CP_W-1:0]  part_reg, part_next;
    logic             fail_reg, fail_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             fire;
    logic             cp_fin;
    logic             has_b, has_e;
    logic [KIND_W-1:0] kind_b, kind_e;
    logic [CP_W-1:0]  cp_b;
    logic [CNT_W-1:0] cnt_b;
    result_t          res_b, res_e;

    assign fire     = valid_reg && space_ok;
    assign in_ready = !valid_reg || fire;
    assign cand_cp  = (rem_reg == 2'd0) ? CP_W'(byte_reg)
                                        : {part_reg[CP_W-7:0], byte_reg[5:0]};

    always_comb begin
        rem_next  = rem_reg;
        part_next = part_reg;
        fail_next = fail_reg;
        cnt_b     = cnt_reg;
        cp_fin    = 1'b0;
        has_b     = 1'b0;
        kind_b    = KIND_OUTSIDE;
        cp_b      = '0;
        if (present_reg && !fail_reg) begin
            if (rem_reg == 2'd0) begin
                case (byte_reg) inside
                    8'b0???????: begin
                        cp_fin = 1'b1;
                    end
                    8'b110?????: begin
                        part_next = CP_W'(byte_reg[4:0]);
                        rem_next  = 2'd1;
                    end
                    8'b1110????: begin
                        part_next = CP_W'(byte_reg[3:0]);
                        rem_next  = 2'd2;
                    end
                    8'b11110???: begin
                        part_next = CP_W'(byte_reg[2:0]);
                        rem_next  = 2'd3;
                    end
                    default: begin
                        fail_next = 1'b1;
                        has_b     = 1'b1;
                        kind_b    = KIND_BAD_LEAD;
                    end
                endcase
            end else if (byte_reg[7:6] != 2'b10) begin
                fail_next = 1'b1;
                has_b     = 1'b1;
                kind_b    = KIND_BAD_CONT;
            end else begin
                part_next = cand_cp;
                rem_next  = rem_reg - 2'd1;
                cp_fin    = (rem_reg == 2'd1);
            end
        end
        if (cp_fin && !hit) begin
            has_b  = 1'b1;
            kind_b = KIND_OUTSIDE;
            cp_b   = cand_cp;
            if (cnt_reg != CNT_MAX) begin
                cnt_b = cnt_reg + CNT_W'(1);
            end
        end
        cnt_next = cnt_b;

        has_e  = end_reg && !fail_next;
        kind_e = (rem_next != 2'd0) ? KIND_TRUNCATED : KIND_END;
        if (end_reg) begin
            rem_next  = '0;
            part_next = '0;
            fail_next = 1'b0;
            cnt_next  = '0;
        end

        res_b = '{kind: kind_b, char_code: cp_b, outside_total: cnt_b, run_last: !has_e};
        res_e = '{kind: kind_e, char_code: '0, outside_total: cnt_b, run_last: 1'b1};

        push.cnt = {1'b0, has_b} + {1'b0, has_e};
        push.r0  = has_b ? res_b : res_e;
        push.r1  = res_e;
        if (!fire) begin
            push.cnt = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            byte_reg    <= in_byte;
            present_reg <= in_present;
            end_reg     <= in_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg  <= '0;
            part_reg <= '0;
            fail_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (fire) begin
            rem_reg  <= rem_next;
            part_reg <= part_next;
            fail_reg <= fail_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== sv/u8rc_out_fifo.sv =====
// Four-entry result queue; takes up to two results a cycle, sends one beat when out_ready is high.
// Depends on u8rc_pkg.
module u8rc_out_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  u8rc_pkg::push_t push,
    output logic            space_ok,
    output logic            out_valid,
    input  logic            out_ready,
    output u8rc_pkg::result_t out_res
);
    import u8rc_pkg::*;

    result_t    mem_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       pop;

    assign out_valid = (count_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign space_ok  = (count_reg <= 3'd2);
    assign out_res   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            mem_reg[wr_ptr_reg + 2'd1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push.cnt;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_reg + {1'b0, push.cnt} - {2'b0, pop};
        end
    end

endmodule

// ===== sv/utf8_codepoint_range_checker.sv =====
// UTF-8 code point range checker, top level. A byte beat taken at the input
// is held in the decode input register; its results are written into the
// result queue and leave from there. Throughput: one byte beat per cycle while the
// queue has space; a beat with two results needs a second output beat, absorbed by the four-entry result queue.
// Reset (aresetn low, synchronous) clears the decode state, count and queue,
// and sets every range empty (first 1, last 0).
module utf8_codepoint_range_checker #(
    parameter int NUM_RANGES = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [u8rc_pkg::S_DATA_W-1:0] s_tdata,  // [7:0] byte_value
    input  logic                          s_tuser,  // [0] byte_present
    input  logic                          s_tlast,  // stream_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [u8rc_pkg::M_DATA_W-1:0] m_tdata,  // [20:0] char_code, [44:21] outside_total
    output logic [u8rc_pkg::KIND_W-1:0]   m_tuser,  // [2:0] result_kind
    output logic                          m_tlast,  // run_last
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [u8rc_pkg::ADDR_W-1:0]   paddr,
    input  logic [u8rc_pkg::DATA_W-1:0]   pwdata,
    output logic [u8rc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import u8rc_pkg::*;

    logic [NUM_RANGES-1:0][RANGE_W-1:0] ranges;
    logic [CP_W-1:0]                    cand_cp;
    logic                               hit;
    logic                               space_ok;
    push_t                              push;
    result_t                            out_res;

    u8rc_cfg_regs #(.NUM_RANGES(NUM_RANGES)) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ranges  (ranges)
    );

    u8rc_range_match #(.NUM_RANGES(NUM_RANGES)) u_match (
        .cp     (cand_cp),
        .ranges (ranges),
        .hit    (hit)
    );

    u8rc_decode u_dec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_present (s_tuser),
        .in_end     (s_tlast),
        .space_ok   (space_ok),
        .hit        (hit),
        .cand_cp    (cand_cp),
        .push       (push)
    );

    u8rc_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {(M_DATA_W - CP_W - CNT_W)'(0), out_res.outside_total, out_res.char_code};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.run_last;

endmodule

// ===== sv/u8rc_checker.sv =====
// Port-level checks for the UTF-8 code point range checker, bound to the top.
// Depends on u8rc_pkg and utf8_codepoint_range_checker.
module u8rc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [u8rc_pkg::M_DATA_W-1:0] m_tdata,
    input logic [u8rc_pkg::KIND_W-1:0]   m_tuser,
    input logic                          m_tlast
);
    import u8rc_pkg::*;

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

    a_hold_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled beat changed");

    a_zero_cp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_OUTSIDE |-> m_tdata[CP_W-1:0] == '0)
        else $error("code point nonzero on a non-outside beat");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_END || m_tuser == KIND_TRUNCATED) |-> m_tlast)
        else $error("end-of-stream beat without tlast");

endmodule

bind utf8_codepoint_range_checker u8rc_checker u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== sim/utf8_range_monitor.sv =====
// Stream and register monitor for the UTF-8 code point range checker: tracks range writes,
// decodes every accepted byte beat into expected result beats and checks the result channel.
// Depends on u8rc_pkg for widths, result kinds and the result layout.
module utf8_range_monitor #(
    parameter int NUM_RANGES = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [u8rc_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [u8rc_pkg::M_DATA_W-1:0] m_tdata,
    input  logic [u8rc_pkg::KIND_W-1:0]   m_tuser,
    input  logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [u8rc_pkg::ADDR_W-1:0]   paddr,
    input  logic [u8rc_pkg::DATA_W-1:0]   pwdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending
);
    import u8rc_pkg::*;

    logic [RANGE_W-1:0] spans [2**IDX_W];
    logic [1:0]         bytes_left;
    logic [CP_W-1:0]    cp_accum;
    logic               stream_dead;
    logic [CNT_W-1:0]   outside_cnt;
    result_t            due_reports [$];

    function automatic logic covered(logic [CP_W-1:0] cp);
        logic [CP_W-1:0] lo, hi;
        for (int i = 0; i < NUM_RANGES; i++) begin
            lo = spans[i][RANGE_W-1:CP_W];
            hi = spans[i][CP_W-1:0];
            if (cp >= lo && cp <= hi) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void post_report(logic [KIND_W-1:0] kind, logic [CP_W-1:0] cp);
        due_reports.push_back('{kind, cp, outside_cnt, 1'b0});
    endfunction

    function automatic void close_cp(logic [CP_W-1:0] cp);
        if (!covered(cp)) begin
            if (outside_cnt != CNT_MAX) outside_cnt++;
            post_report(KIND_OUTSIDE, cp);
        end
    endfunction

    task automatic decode_byte_beat(logic [7:0] b, logic present, logic fin);
        int      start_n;
        result_t tail;
        start_n = due_reports.size();
        if (present && !stream_dead) begin
            if (bytes_left == 2'd0) begin
                if (b[7] == 1'b0) begin
                    close_cp(CP_W'(b[6:0]));
                end else if (b[7:5] == 3'b110) begin
                    cp_accum   = CP_W'(b[4:0]);
                    bytes_left = 2'd1;
                end else if (b[7:4] == 4'b1110) begin
                    cp_accum   = CP_W'(b[3:0]);
                    bytes_left = 2'd2;
                end else if (b[7:3] == 5'b11110) begin
                    cp_accum   = CP_W'(b[2:0]);
                    bytes_left = 2'd3;
                end else begin
                    stream_dead = 1'b1;
                    post_report(KIND_BAD_LEAD, '0);
                end
            end else if (b[7:6] != 2'b10) begin
                stream_dead = 1'b1;
                post_report(KIND_BAD_CONT, '0);
            end else begin
                cp_accum   = {cp_accum[CP_W-7:0], b[5:0]};
                bytes_left = bytes_left - 2'd1;
                if (bytes_left == 2'd0) close_cp(cp_accum);
            end
        end
        if (fin) begin
            if (!stream_dead) post_report(bytes_left != 2'd0 ? KIND_TRUNCATED : KIND_END, '0);
            bytes_left  = '0;
            cp_accum    = '0;
            stream_dead = 1'b0;
            outside_cnt = '0;
        end
        if (due_reports.size() > start_n) begin
            tail          = due_reports.pop_back();
            tail.run_last = 1'b1;
            due_reports.push_back(tail);
        end
    endtask

    task automatic check_result_beat();
        result_t want;
        if (due_reports.size() == 0) begin
            $error("unexpected result beat: result_kind %0d char_code %h", m_tuser,
                   m_tdata[CP_W-1:0]);
            fail_count++;
        end else begin
            want = due_reports.pop_front();
            if (m_tuser !== want.kind) begin
                $error("result_kind: expected %0d, got %0d", want.kind, m_tuser);
                fail_count++;
            end
            if (m_tdata[CP_W-1:0] !== want.char_code) begin
                $error("char_code: expected %h, got %h", want.char_code, m_tdata[CP_W-1:0]);
                fail_count++;
            end
            if (m_tdata[CP_W +: CNT_W] !== want.outside_total) begin
                $error("outside_total: expected %0d, got %0d", want.outside_total,
                       m_tdata[CP_W +: CNT_W]);
                fail_count++;
            end
            if (m_tlast !== want.run_last) begin
                $error("run_last: expected %0b, got %0b", want.run_last, m_tlast);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (spans[i]) spans[i] = RANGE_RESET;
            bytes_left  = '0;
            cp_accum    = '0;
            stream_dead = 1'b0;
            outside_cnt = '0;
            due_reports.delete();
        end else begin
            if (psel && penable && pwrite && pready)
                spans[paddr[ADDR_W-1:3]] = pwdata[RANGE_W-1:0];
            if (m_tvalid && m_tready) check_result_beat();
            if (s_tvalid && s_tready) decode_byte_beat(s_tdata, s_tuser, s_tlast);
        end
        pending = due_reports.size();
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the UTF-8 code point range checker bench: clock, reset, range register writes
// and byte stream stimulus with random idling; the verdict comes from utf8_range_monitor.
// Depends on u8rc_pkg, utf8_codepoint_range_checker and utf8_range_monitor.
module testbench;
    import u8rc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        SPAN_RANDOM,
        SPAN_ZERO,
        SPAN_ONES,
        SPAN_WITH_FULL,
        SPAN_DIRECTED
    } span_style_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]   m_tuser;
    logic                m_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int                  fail_count;
    int                  pending;
    int                  items_sent;
    int                  stall_left;
    int unsigned         cycle_count;
    bit                  idle_on;
    logic [RANGE_W-1:0]  cur_span [2**IDX_W];

    utf8_codepoint_range_checker #(.NUM_RANGES(8)) dut (.*);

    utf8_range_monitor #(.NUM_RANGES(8)) monitor (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("utf8_codepoint_range_checker: mismatch");
            $finish;
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) stall_left--;
            else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
            m_tready = (stall_left == 0);
        end
    end

    function automatic logic [7:0] utf8_byte(logic [CP_W-1:0] cp, int n, int i);
        logic [CP_W-1:0] part;
        part = cp >> (6 * (n - 1 - i));
        if (i > 0) return {2'b10, part[5:0]};
        case (n)
            1:       return {1'b0, part[6:0]};
            2:       return {3'b110, part[4:0]};
            3:       return {4'b1110, part[3:0]};
            default: return {5'b11110, part[2:0]};
        endcase
    endfunction

    function automatic int cp_len(logic [CP_W-1:0] cp);
        int n;
        n = cp < 'h80 ? 1 : cp < 'h800 ? 2 : cp < 'h10000 ? 3 : 4;
        if ($urandom_range(0, 7) == 0) n = $urandom_range(n, 4);
        return n;
    endfunction

    function automatic logic [CP_W-1:0] pick_cp();
        logic [RANGE_W-1:0] s;
        logic [CP_W-1:0]    edge_cp;
        s = cur_span[$urandom_range(0, 7)];
        edge_cp = $urandom_range(0, 1) ? s[RANGE_W-1:CP_W] : s[CP_W-1:0];
        case ($urandom_range(0, 3))
            0:       return CP_W'($urandom);
            1:       return CP_W'($urandom_range(0, 'h7F));
            2:       return CP_W'($urandom_range(0, 'hFFFF));
            default: return edge_cp + CP_W'($urandom_range(0, 2)) - CP_W'(1);
        endcase
    endfunction

    function automatic logic [RANGE_W-1:0] rand_span();
        logic [CP_W-1:0] lo, hi, t;
        lo = CP_W'($urandom);
        hi = CP_W'($urandom);
        case ($urandom_range(0, 3))
            0: ;
            1: if (lo > hi) begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            2: begin
                lo = CP_W'($urandom_range(0, 'h7FF));
                hi = lo + CP_W'($urandom_range(0, 'h200));
            end
            default: hi = lo;
        endcase
        return {lo, hi};
    endfunction

    task automatic send_beat(logic [7:0] b, logic present, logic fin);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = present;
        s_tlast  = fin;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_cp(logic [CP_W-1:0] cp, int n, int nsend, logic fin);
        for (int i = 0; i < nsend; i++)
            send_beat(utf8_byte(cp, n, i), 1'b1, fin && i == nsend - 1);
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic cfg_write(int idx, logic [RANGE_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(idx * 8);
        pwdata  = {(DATA_W - RANGE_W)'($urandom), value};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_spans(span_style_t style);
        int full_slot;
        full_slot = $urandom_range(0, 7);
        foreach (cur_span[i]) begin
            case (style)
                SPAN_ZERO:      cur_span[i] = '0;
                SPAN_ONES:      cur_span[i] = '1;
                SPAN_WITH_FULL: cur_span[i] = i == full_slot ? {21'h0, 21'h1FFFFF} : rand_span();
                default:        cur_span[i] = rand_span();
            endcase
        end
        if (style == SPAN_DIRECTED) begin
            cur_span[0] = {21'h000000, 21'h00007F};
            cur_span[1] = {21'h0000A9, 21'h0000A9};
            cur_span[2] = {21'h01F600, 21'h01F64F};
            cur_span[3] = {21'h0020AC, 21'h0020AC};
            cur_span[4] = {21'h000100, 21'h0000FF};
            cur_span[5] = {21'h1FFFFF, 21'h1FFFFF};
            cur_span[6] = {21'h003000, 21'h00303F};
            cur_span[7] = {21'h000000, 21'h000000};
        end
        foreach (cur_span[i]) cfg_write(i, cur_span[i]);
    endtask

    task automatic run_stream();
        int              nchar, pick, n;
        logic            fin;
        logic [CP_W-1:0] cp;
        nchar = $urandom_range(0, 10);
        for (int c = 0; c < nchar; c++) begin
            pick = $urandom_range(0, 29);
            if (pick == 0) begin
                send_beat(8'($urandom), 1'b1, 1'b0);
            end else if (pick == 1) begin
                send_beat(8'($urandom), 1'b0, 1'b0);
            end else begin
                cp = pick_cp();
                n  = cp_len(cp);
                send_cp(cp, n, n, 1'b0);
            end
        end
        pick = $urandom_range(0, 9);
        cp   = pick_cp();
        n    = cp_len(cp);
        if (pick < 4) begin
            send_beat(8'($urandom), 1'b0, 1'b1);
        end else if (pick < 8) begin
            send_cp(cp, n, n, 1'b1);
        end else if (pick == 8) begin
            send_beat(8'($urandom), 1'b1, 1'b1);
        end else begin
            n   = $urandom_range(2, 4);
            fin = 1'($urandom_range(0, 1));
            send_cp(cp, n, $urandom_range(1, n - 1), fin);
            if (!fin) send_beat(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic run_phase(int count);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop) run_stream();
        settle();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        idle_on  = 1'b1;
        foreach (cur_span[i]) cur_span[i] = RANGE_RESET;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // all ranges empty after reset: every code point is reported
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'h7F, 1'b1, 1'b0);
        send_cp(21'h0000A9, 2, 2, 1'b0);
        send_beat(8'h5A, 1'b0, 1'b1);
        settle();

        apply_spans(SPAN_DIRECTED);
        send_cp(21'h1FFFFF, 4, 4, 1'b0);
        send_cp(21'h01F600, 4, 4, 1'b0);
        send_cp(21'h0020AD, 3, 3, 1'b0);
        send_cp(21'h0000FF, 2, 2, 1'b0);
        send_cp(21'h000080, 2, 2, 1'b1);
        // absent byte, bad lead, then an ignored byte and a silent end
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h80, 1'b1, 1'b0);
        send_beat(8'h41, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        // bad continuation
        send_beat(8'hC3, 1'b1, 1'b0);
        send_beat(8'h41, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b1);
        // bad lead on the end beat
        send_beat(8'hF8, 1'b1, 1'b1);
        // truncated sequence
        send_beat(8'hE2, 1'b1, 1'b0);
        send_beat(8'h82, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        settle();

        apply_spans(SPAN_RANDOM);
        run_phase(240);
        apply_spans(SPAN_ZERO);
        run_phase(200);
        apply_spans(SPAN_ONES);
        run_phase(200);
        apply_spans(SPAN_WITH_FULL);
        run_phase(200);
        idle_on = 1'b0;
        apply_spans(SPAN_RANDOM);
        run_phase(260);

        if (fail_count == 0)
            $display("utf8_codepoint_range_checker: match");
        else
            $display("utf8_codepoint_range_checker: mismatch");
        $finish;
    end

endmodule
